// ===== rtl/reprogram_entry_gate_fsm_assert.svh =====
// Assertion shorthands used by the checker file.
`ifndef REPROGRAM_ENTRY_GATE_FSM_ASSERT_SVH
`define REPROGRAM_ENTRY_GATE_FSM_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RPRG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rprg_gate: same-cycle check failed");

// next-cycle implication
`define RPRG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rprg_gate: next-cycle check failed");

`endif

// ===== rtl/rprg_gate_pkg.sv =====
`default_nettype none
package rprg_gate_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int CFG_W           = 16;

	// function codes (s_tuser)
	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_ACT    = 2'd1;
	localparam logic [1:0] FUNC_RUN    = 2'd2;
	localparam logic [1:0] FUNC_CANCEL = 2'd3;

	// status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_NOT_OK  = 2'd1;
	localparam logic [1:0] STS_PENDING = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_VOLT  = 2'd1;
	localparam logic [1:0] ERR_SPEED = 2'd2;
	localparam logic [1:0] ERR_COND  = 2'd3;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_RUN_DELAY = 2'd0;
	localparam logic [1:0] REG_SPEED_MIN = 2'd1;
	localparam logic [1:0] REG_SPEED_UNK = 2'd2;
	localparam logic [1:0] REG_ACT_DELAY = 2'd3;

	// register reset values
	localparam logic [CFG_W-1:0] RUN_DELAY_RST = 16'd100;
	localparam logic [CFG_W-1:0] SPEED_MIN_RST = 16'd500;
	localparam logic [CFG_W-1:0] SPEED_UNK_RST = 16'hFFFF;
	localparam logic [CFG_W-1:0] ACT_DELAY_RST = 16'd20;

	typedef enum logic [5:0] {
		ST_PRE_RUN   = 6'b000001,
		ST_REQ_ACT   = 6'b000010,
		ST_RDY_ACT   = 6'b000100,
		ST_VOL_INACT = 6'b001000,
		ST_SP_INACT  = 6'b010000,
		ST_INACT     = 6'b100000
	} ctrl_state_t;

	typedef struct packed {
		logic [CFG_W-1:0] run_delay;
		logic [CFG_W-1:0] speed_min;
		logic [CFG_W-1:0] speed_unk;
		logic [CFG_W-1:0] act_delay;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        check_ok;
		logic [15:0] speed;
		logic        reprog_enable;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  error_code;
		logic        prep_report;
		logic [15:0] prep_count;
		logic        cancel_notice;
		logic        reset_request;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/rprg_gate_cfg.sv =====
`default_nettype none
module rprg_gate_cfg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	output rprg_gate_pkg::cfg_t       cfg
);
	import rprg_gate_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_delay <= RUN_DELAY_RST;
			cfg_q.speed_min <= SPEED_MIN_RST;
			cfg_q.speed_unk <= SPEED_UNK_RST;
			cfg_q.act_delay <= ACT_DELAY_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_RUN_DELAY: cfg_q.run_delay <= pwdata[CFG_W-1:0];
				REG_SPEED_MIN: cfg_q.speed_min <= pwdata[CFG_W-1:0];
				REG_SPEED_UNK: cfg_q.speed_unk <= pwdata[CFG_W-1:0];
				REG_ACT_DELAY: cfg_q.act_delay <= pwdata[CFG_W-1:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RUN_DELAY: prdata = 32'(cfg_q.run_delay);
			REG_SPEED_MIN: prdata = 32'(cfg_q.speed_min);
			REG_SPEED_UNK: prdata = 32'(cfg_q.speed_unk);
			REG_ACT_DELAY: prdata = 32'(cfg_q.act_delay);
			default:       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/rprg_gate_core.sv =====
`default_nettype none
module rprg_gate_core #(
	parameter int TIMER_WIDTH = rprg_gate_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 commit,
	input  wire rprg_gate_pkg::item_t item,
	input  wire rprg_gate_pkg::cfg_t  cfg,
	output rprg_gate_pkg::result_t    res
);
	import rprg_gate_pkg::*;

	// compare width covers both the timers and the 16-bit registers
	localparam int CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam logic [TIMER_WIDTH-1:0] TMAX = '1;
	localparam logic [TIMER_WIDTH-1:0] TONE = TIMER_WIDTH'(1);

	ctrl_state_t            cs_q, cs_nx;
	logic [TIMER_WIDTH-1:0] prep_q, prep_nx, prep_tk;
	logic [TIMER_WIDTH-1:0] sot_q, sot_nx, sot_tk;
	logic [CW-1:0]          run_x, act_x;
	logic                   speed_hi, sot_bad;

	assign run_x = CW'(cfg.run_delay);
	assign act_x = CW'(cfg.act_delay);

	assign speed_hi = (item.speed > cfg.speed_min) && (item.speed < cfg.speed_unk);

	// low-speed timer: all ones = stopped, then counts up and parks at act delay
	always_comb begin
		if (speed_hi)
			sot_tk = TMAX;
		else if (sot_q == TMAX)
			sot_tk = '0;
		else if (CW'(sot_q) >= act_x)
			sot_tk = TIMER_WIDTH'(act_x);
		else
			sot_tk = sot_q + TONE;
	end

	assign sot_bad = (sot_tk == TMAX) || (CW'(sot_tk) < act_x);

	// preparation timer restarts when leaving activation-requested
	always_comb begin
		if (cs_q == ST_REQ_ACT)
			prep_tk = '0;
		else if (prep_q != TMAX)
			prep_tk = prep_q + TONE;
		else
			prep_tk = prep_q;
	end

	always_comb begin
		cs_nx   = cs_q;
		prep_nx = prep_q;
		sot_nx  = sot_q;
		res     = '0;
		case (item.func)
			FUNC_TICK: begin
				sot_nx  = sot_tk;
				prep_nx = prep_tk;
				if (!item.reprog_enable) begin
					cs_nx   = ST_VOL_INACT;
					prep_nx = TMAX;
				end else if (sot_bad) begin
					cs_nx   = ST_SP_INACT;
					prep_nx = TMAX;
				end else begin
					unique case (cs_q) inside
						ST_PRE_RUN, ST_REQ_ACT: cs_nx = ST_PRE_RUN;
						ST_RDY_ACT, ST_VOL_INACT, ST_SP_INACT, ST_INACT:
							cs_nx = ST_RDY_ACT;
						default: begin
							cs_nx   = ST_INACT;
							prep_nx = TMAX;
						end
					endcase
				end
				if (CW'(prep_nx) <= run_x) begin
					res.prep_report = 1'b1;
					res.prep_count  = 16'(prep_nx);
				end
			end
			FUNC_ACT: begin
				unique case (cs_q) inside
					ST_VOL_INACT: begin
						res.status     = STS_NOT_OK;
						res.error_code = ERR_VOLT;
					end
					ST_SP_INACT: begin
						res.status     = STS_NOT_OK;
						res.error_code = ERR_SPEED;
					end
					ST_RDY_ACT: begin
						if (item.check_ok)
							cs_nx = ST_REQ_ACT;
						else begin
							res.status     = STS_NOT_OK;
							res.error_code = ERR_COND;
						end
					end
					ST_PRE_RUN, ST_REQ_ACT: begin
						if (!item.check_ok) begin
							res.status     = STS_NOT_OK;
							res.error_code = ERR_COND;
						end
					end
					default: begin
						res.status     = STS_NOT_OK;
						res.error_code = ERR_COND;
					end
				endcase
			end
			FUNC_RUN: begin
				if (cs_q != ST_PRE_RUN && cs_q != ST_REQ_ACT)
					res.status = STS_NOT_OK;
				else if (CW'(prep_q) >= run_x)
					res.status = STS_OK;
				else
					res.status = STS_PENDING;
			end
			default: begin
				cs_nx             = ST_RDY_ACT;
				prep_nx           = TMAX;
				res.cancel_notice = 1'b1;
			end
		endcase
		res.reset_request = (cs_nx == ST_PRE_RUN) && (CW'(prep_nx) >= run_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q   <= ST_RDY_ACT;
			prep_q <= TMAX;
			sot_q  <= TMAX;
		end else if (commit) begin
			cs_q   <= cs_nx;
			prep_q <= prep_nx;
			sot_q  <= sot_nx;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/reprogram_entry_gate_fsm.sv =====
// Reprogramming entry gate: control machine plus low-speed and preparation timers.
// An accepted request passes the input reg, then the result reg, to result valid.
// 1 request per cycle while m_tready is high; a stalled result reg holds stage 1.
// Reset (arst_n low, async): state ready-to-activate, both timers all ones,
// registers at their defaults, both pipeline stages empty.
`default_nettype none
module reprogram_entry_gate_fsm #(
	parameter int TIMER_WIDTH = rprg_gate_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // [0] check_ok, [16:1] speed, [17] reprog_enable
	input  wire logic [1:0]  s_tuser,  // [1:0] func
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] status, [3:2] error_code, [4] prep_report, [20:5] prep_count,
	// [21] cancel_notice, [22] reset_request
	output logic [23:0]      m_tdata,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import rprg_gate_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_c, res_q;
	logic    out_valid_q;
	logic    adv;

	// stage 1 moves into the result register when that register is free or draining
	assign adv      = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | adv;

	rprg_gate_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// state and timers change only when the item leaves stage 1
	rprg_gate_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func          <= s_tuser;
			item_s1.check_ok      <= s_tdata[0];
			item_s1.speed         <= s_tdata[16:1];
			item_s1.reprog_enable <= s_tdata[17];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (~out_valid_q | m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.reset_request, res_q.cancel_notice, res_q.prep_count,
		res_q.prep_report, res_q.error_code, res_q.status};

endmodule
`default_nettype wire

// ===== rtl/rprg_gate_chk.sv =====
`default_nettype none
`include "reprogram_entry_gate_fsm_assert.svh"
module rprg_gate_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);
	import rprg_gate_pkg::*;

	// cancel always answers ok with no error and no reset request (the machine is left ready)
	`RPRG_ASSERT_NOW(a_cancel_clean, m_tvalid && m_tdata[21], m_tdata[1:0] == STS_OK && m_tdata[3:2] == ERR_NONE && !m_tdata[22])
	// a count is only shown together with its report flag
	`RPRG_ASSERT_NOW(a_count_gated, m_tvalid && !m_tdata[4], m_tdata[20:5] == 16'd0)
	// error codes only come with not-ok
	`RPRG_ASSERT_NOW(a_err_not_ok, m_tvalid && m_tdata[3:2] != ERR_NONE, m_tdata[1:0] == STS_NOT_OK)
	// stalled result holds
	`RPRG_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind reprogram_entry_gate_fsm rprg_gate_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
